### hw/rtl/srpd_pkg.sv
// Shared types and constants for the spectrum range peak detector.
// No dependencies; imported by every srpd module and the top level.
package srpd_pkg;

	localparam int FREQ_W      = 33;
	localparam int PWR_W       = 16;
	localparam int THR_W       = 17;
	localparam int SNR_W       = 18;
	localparam int MAX_BINS    = 4096;
	localparam int NUM_WINDOWS = 3;
	localparam int WIN_CNT_W   = 2;
	localparam int COUNT_W     = $clog2(MAX_BINS + 1);
	localparam int SUM_W       = PWR_W + $clog2(MAX_BINS);
	localparam int DIV_CNT_W   = $clog2(SUM_W);
	localparam int FIFO_DEPTH  = 2;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = FREQ_W;

	localparam logic signed [PWR_W-1:0] PEAK_RESET = {1'b1, {(PWR_W-1){1'b0}}};

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THR_OFFSET = 3'd0,
		REG_WIN_COUNT  = 3'd1,
		REG_W0_LOW     = 3'd2,
		REG_W0_HIGH    = 3'd3,
		REG_W1_LOW     = 3'd4,
		REG_W1_HIGH    = 3'd5,
		REG_W2_LOW     = 3'd6,
		REG_W2_HIGH    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [PWR_W-1:0]               thr_offset;
		logic [WIN_CNT_W-1:0]                  win_count;
		logic [NUM_WINDOWS-1:0][FREQ_W-1:0]    win_low;
		logic [NUM_WINDOWS-1:0][FREQ_W-1:0]    win_high;
	} cfg_t;

	// per-frame totals handed from front to back
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [COUNT_W-1:0]      count;
		logic signed [PWR_W-1:0] peak;
		logic                    seen;
	} frame_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_OUT
	} back_state_t;

endpackage

### hw/rtl/srpd_front.sv
// Front end: window classification and per-frame accumulation of bins.
// Depends on srpd_pkg; pushes one frame_t per frame into the frame queue.
module srpd_front import srpd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    push,
	output logic                    full,
	input  logic [FREQ_W-1:0]       bin_freq,
	input  logic signed [PWR_W-1:0] bin_power,
	input  logic                    last_bin,
	output logic                    frm_push,
	output frame_t                  frm_data,
	input  logic                    frm_full
);

	logic signed [SUM_W-1:0] sum_q;
	logic [COUNT_W-1:0]      count_q;
	logic signed [PWR_W-1:0] peak_q;
	logic                    seen_q;

	logic                    take;
	logic                    in_win;
	logic signed [SUM_W-1:0] sum_nxt;
	logic [COUNT_W-1:0]      count_nxt;
	logic signed [PWR_W-1:0] peak_nxt;
	logic                    seen_nxt;

	assign full = frm_full;
	assign take = push && !frm_full;

	always_comb begin
		in_win = 1'b0;
		for (int k = 0; k < NUM_WINDOWS; k++) begin
			if ((k < int'(cfg.win_count)) && (bin_freq > cfg.win_low[k]) &&
					(bin_freq < cfg.win_high[k])) begin
				in_win = 1'b1;
			end
		end
	end

	always_comb begin
		seen_nxt  = seen_q | in_win;
		peak_nxt  = (in_win && (bin_power > peak_q)) ? bin_power : peak_q;
		sum_nxt   = sum_q;
		count_nxt = count_q;
		// count saturates; bins past the limit only feed the peak and the seen flag
		if (count_q < COUNT_W'(MAX_BINS)) begin
			sum_nxt   = sum_q + signed'({{(SUM_W-PWR_W){bin_power[PWR_W-1]}}, bin_power});
			count_nxt = count_q + COUNT_W'(1);
		end
	end

	assign frm_push       = take && last_bin;
	assign frm_data.sum   = sum_nxt;
	assign frm_data.count = count_nxt;
	assign frm_data.peak  = peak_nxt;
	assign frm_data.seen  = seen_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			peak_q  <= PEAK_RESET;
			seen_q  <= 1'b0;
		end else if (take) begin
			if (last_bin) begin
				sum_q   <= '0;
				count_q <= '0;
				peak_q  <= PEAK_RESET;
				seen_q  <= 1'b0;
			end else begin
				sum_q   <= sum_nxt;
				count_q <= count_nxt;
				peak_q  <= peak_nxt;
				seen_q  <= seen_nxt;
			end
		end
	end

	// peak only moves off its floor once an in-window bin was seen
	a_peak_floor: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> (peak_q == PEAK_RESET))
		else $error("peak moved without an in-window bin");

endmodule

### hw/rtl/srpd_fifo.sv
// Short queue of finished frame totals between front and back.
// Depends on srpd_pkg for frame_t and the queue depth.
module srpd_fifo import srpd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  frame_t wr_data,
	output logic   full,
	input  logic   rd_en,
	output frame_t rd_data,
	output logic   empty
);

	frame_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	logic do_wr;
	logic do_rd;

	assign full    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("frame queue fill count past depth");

endmodule

### hw/rtl/srpd_back.sv
// Back end: bit-serial mean divider, threshold/SNR/detect and result register.
// Depends on srpd_pkg; pops frame_t records from the frame queue.
module srpd_back import srpd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [PWR_W-1:0] thr_offset,
	input  frame_t                  frm_data,
	input  logic                    frm_empty,
	output logic                    frm_pop,
	output logic                    empty,
	input  logic                    pop,
	output logic                    detected,
	output logic                    indicator_changed,
	output logic                    any_in_window,
	output logic signed [PWR_W-1:0] mean_power,
	output logic signed [THR_W-1:0] threshold_level,
	output logic signed [PWR_W-1:0] peak_power,
	output logic signed [SNR_W-1:0] snr_value
);

	back_state_t state_q;
	back_state_t state_nxt;

	logic [DIV_CNT_W-1:0]    div_cnt_q;
	logic [SUM_W-1:0]        dvd_q;
	logic [COUNT_W-1:0]      rem_q;
	logic [COUNT_W-1:0]      dvsr_q;
	logic                    neg_q;
	logic signed [PWR_W-1:0] peak_q;
	logic                    seen_q;
	logic                    ind_q;
	logic                    out_vld_q;

	logic                    load_frm;
	logic                    div_step;
	logic                    load_out;
	logic [COUNT_W:0]        trial;
	logic                    q_bit;
	logic [SUM_W-1:0]        mean_full;
	logic signed [PWR_W-1:0] mean_s;
	logic signed [THR_W-1:0] thr_s;
	logic signed [SNR_W-1:0] snr_s;
	logic                    det_s;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!frm_empty) begin
					state_nxt = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
					state_nxt = BK_OUT;
				end
			end
			BK_OUT: begin
				if (!out_vld_q || pop) begin
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		load_frm = 1'b0;
		div_step = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: load_frm = !frm_empty;
			BK_DIV:  div_step = 1'b1;
			BK_OUT:  load_out = !out_vld_q || pop;
			default: ;
		endcase
	end

	assign frm_pop = load_frm;
	assign empty   = !out_vld_q;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign q_bit = (trial >= {1'b0, dvsr_q});

	// result math, valid in BK_OUT
	assign mean_full = neg_q ? (SUM_W'(0) - dvd_q) : dvd_q;
	assign mean_s    = signed'(mean_full[PWR_W-1:0]);
	assign thr_s     = signed'({mean_s[PWR_W-1], mean_s}) +
		signed'({thr_offset[PWR_W-1], thr_offset});
	assign snr_s     = signed'({{(SNR_W-PWR_W){peak_q[PWR_W-1]}}, peak_q}) -
		signed'({thr_s[THR_W-1], thr_s});
	assign det_s     = seen_q && !snr_s[SNR_W-1] && (snr_s != '0);

	always_ff @(posedge clk) begin
		if (load_frm) begin
			dvd_q  <= frm_data.sum[SUM_W-1] ? (SUM_W'(0) - frm_data.sum) : frm_data.sum;
			neg_q  <= frm_data.sum[SUM_W-1];
			dvsr_q <= frm_data.count;
			rem_q  <= '0;
			peak_q <= frm_data.peak;
			seen_q <= frm_data.seen;
		end else if (div_step) begin
			rem_q <= q_bit ? COUNT_W'(trial - {1'b0, dvsr_q}) : trial[COUNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], q_bit};
		end
		if (load_out) begin
			detected          <= det_s;
			indicator_changed <= det_s != ind_q;
			any_in_window     <= seen_q;
			mean_power        <= mean_s;
			threshold_level   <= thr_s;
			peak_power        <= peak_q;
			snr_value         <= snr_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			div_cnt_q <= '0;
			ind_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_frm) begin
				div_cnt_q <= '0;
			end else if (div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (load_out) begin
				ind_q     <= det_s;
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	a_dvsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (dvsr_q != '0))
		else $error("divide by zero bin count");

	// an average of Q8.8 powers never leaves the Q8.8 range
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_OUT) |-> (dvd_q <= SUM_W'(32768)))
		else $error("mean quotient out of range");

endmodule

### hw/rtl/spectrum_range_peak_detector.sv
// Top level of the spectrum range peak detector: config registers and wiring.
// Depends on srpd_pkg, srpd_front, srpd_fifo and srpd_back.
//
// Bins enter one per clock through push/full; full rises only when two finished
// frames are already waiting for the back end. At each last bin the frame totals
// move into that two-entry queue, and the back end turns each into one result:
// a bit-serial divide (one quotient bit per cycle) for the mean, then threshold,
// SNR and detect, then a step to pick the next frame. While results are popped,
// frames with at least as many bins as the back end spends cycles per frame run
// at one bin per clock; shorter frames are paced by the divider. The result sits
// in an output register on empty/pop, and the back end keeps dividing the next
// frame while it waits. The detect indicator is held across frames and drives
// indicator_changed. Config writes are always taken (cfg_ready is tied high) and
// must only be issued while no frame is in flight. Unknown indices are dropped.
module spectrum_range_peak_detector import srpd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// bin input
	input  logic                    push,
	output logic                    full,
	input  logic [FREQ_W-1:0]       bin_freq,
	input  logic signed [PWR_W-1:0] bin_power,
	input  logic                    last_bin,
	// frame result
	output logic                    empty,
	input  logic                    pop,
	output logic                    detected,
	output logic                    indicator_changed,
	output logic                    any_in_window,
	output logic signed [PWR_W-1:0] mean_power,
	output logic signed [THR_W-1:0] threshold_level,
	output logic signed [PWR_W-1:0] peak_power,
	output logic signed [SNR_W-1:0] snr_value,
	// config write
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	cfg_t   cfg_q;
	logic   frm_push;
	frame_t frm_wr;
	logic   frm_full;
	logic   frm_pop;
	frame_t frm_rd;
	logic   frm_empty;

	assign cfg_ready = 1'b1;

	// register file; each transaction writes one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_offset <= '0;
			cfg_q.win_count  <= WIN_CNT_W'(1);
			cfg_q.win_low    <= '0;
			cfg_q.win_high   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_THR_OFFSET: cfg_q.thr_offset  <= signed'(cfg_data[PWR_W-1:0]);
				REG_WIN_COUNT:  cfg_q.win_count   <= cfg_data[WIN_CNT_W-1:0];
				REG_W0_LOW:     cfg_q.win_low[0]  <= cfg_data;
				REG_W0_HIGH:    cfg_q.win_high[0] <= cfg_data;
				REG_W1_LOW:     cfg_q.win_low[1]  <= cfg_data;
				REG_W1_HIGH:    cfg_q.win_high[1] <= cfg_data;
				REG_W2_LOW:     cfg_q.win_low[2]  <= cfg_data;
				REG_W2_HIGH:    cfg_q.win_high[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	srpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.bin_freq  (bin_freq),
		.bin_power (bin_power),
		.last_bin  (last_bin),
		.frm_push  (frm_push),
		.frm_data  (frm_wr),
		.frm_full  (frm_full)
	);

	srpd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (frm_push),
		.wr_data (frm_wr),
		.full    (frm_full),
		.rd_en   (frm_pop),
		.rd_data (frm_rd),
		.empty   (frm_empty)
	);

	srpd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.thr_offset        (cfg_q.thr_offset),
		.frm_data          (frm_rd),
		.frm_empty         (frm_empty),
		.frm_pop           (frm_pop),
		.empty             (empty),
		.pop               (pop),
		.detected          (detected),
		.indicator_changed (indicator_changed),
		.any_in_window     (any_in_window),
		.mean_power        (mean_power),
		.threshold_level   (threshold_level),
		.peak_power        (peak_power),
		.snr_value         (snr_value)
	);

endmodule
